// ===== rtl/adts_stream_deframer_defines.svh =====
// ---------------------------------------------------------------------------
// ADTS stream deframer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge.
// ---------------------------------------------------------------------------
`ifndef ADTS_STREAM_DEFRAMER_DEFINES_SVH
`define ADTS_STREAM_DEFRAMER_DEFINES_SVH

// same-cycle implication, gated off during reset
`define ADTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adts: same-cycle check failed");

// next-cycle implication, gated off during reset
`define ADTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adts: next-cycle check failed");

`endif

// ===== rtl/adts_pkg.sv =====
// ---------------------------------------------------------------------------
// ADTS deframer package
// Payload types, byte label codes and the sample rate table.
// ---------------------------------------------------------------------------
package adts_pkg;

   localparam int ByteW  = 8;
   localparam int LenW   = 13;
   localparam int RateW  = 4;
   localparam int HzW    = 17;
   localparam int KindW  = 2;

   localparam logic [KindW-1:0] KIND_TAG     = 2'd0;
   localparam logic [KindW-1:0] KIND_HEADER  = 2'd1;
   localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [KindW-1:0] KIND_REJECT  = 2'd3;

   typedef struct packed {
      logic [ByteW-1:0] byte_value;
      logic             restart;
   } req_payload_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic [KindW-1:0] byte_kind;
      logic             frame_last;
      logic [LenW-1:0]  frame_length;
      logic [RateW-1:0] rate_index;
      logic [HzW-1:0]   sample_rate;
      logic             sync_error;
   } rsp_payload_type;

   // input register contents handed to the parser
   typedef struct packed {
      logic            vld;
      req_payload_type data;
   } stage_type;

   function automatic logic [HzW-1:0] rate_hz(input logic [RateW-1:0] idx);
      logic [HzW-1:0] hz;
      unique case (idx)
         4'd0:    hz = 17'd96000;
         4'd1:    hz = 17'd88200;
         4'd2:    hz = 17'd64000;
         4'd3:    hz = 17'd48000;
         4'd4:    hz = 17'd44100;
         4'd5:    hz = 17'd32000;
         4'd6:    hz = 17'd24000;
         4'd7:    hz = 17'd22050;
         4'd8:    hz = 17'd16000;
         4'd9:    hz = 17'd12000;
         4'd10:   hz = 17'd11025;
         4'd11:   hz = 17'd8000;
         4'd12:   hz = 17'd7350;
         default: hz = '0;
      endcase
      return hz;
   endfunction

endpackage

// ===== rtl/adts_if.sv =====
// ---------------------------------------------------------------------------
// ADTS deframer channels
// Valid/ready channels for stream bytes in and labeled bytes out.
// ---------------------------------------------------------------------------
interface adts_req_if;
   logic                     valid;
   logic                     ready;
   adts_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface adts_rsp_if;
   logic                     valid;
   logic                     ready;
   adts_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/adts_in_stage.sv =====
// ---------------------------------------------------------------------------
// ADTS input stage
// Registers one incoming byte; refills in the cycle the parser drains it.
// ---------------------------------------------------------------------------
module adts_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  adts_pkg::req_payload_type in_data,
   input  logic                      adv,
   output adts_pkg::stage_type       stage
);

   logic                      vld_ff, vld_in;
   adts_pkg::req_payload_type data_ff;
   logic                      take;

   assign in_ready = !vld_ff || adv;
   assign take     = in_valid && in_ready;
   assign vld_in   = take || (vld_ff && !adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= in_data;
      end
   end

   assign stage.vld  = vld_ff;
   assign stage.data = data_ff;

endmodule

// ===== rtl/adts_parser.sv =====
// ---------------------------------------------------------------------------
// ADTS parser
// Tag skip and frame header walk for one byte, into the result register.
// ---------------------------------------------------------------------------
`include "adts_stream_deframer_defines.svh"

module adts_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  adts_pkg::stage_type       stage,
   output logic                      adv,
   output logic                      out_valid,
   input  logic                      out_ready,
   output adts_pkg::rsp_payload_type out_data
);

   localparam logic [2:0] PH_START    = 3'd0;
   localparam logic [2:0] PH_TAG_HEAD = 3'd1;
   localparam logic [2:0] PH_TAG_BODY = 3'd2;
   localparam logic [2:0] PH_FRAME    = 3'd3;
   localparam logic [2:0] PH_ERROR    = 3'd4;

   localparam int LeftW = 29;
   localparam int LenW  = adts_pkg::LenW;

   logic [2:0]       phase_ff, phase_in;
   logic [3:0]       tidx_ff, tidx_in;
   logic [LeftW-1:0] left_ff, left_in;
   logic [LenW-1:0]  pos_ff, pos_in;
   logic [LenW-1:0]  len_ff, len_in;
   logic [3:0]       rate_ff, rate_in;
   logic             err_ff, err_in;
   logic             out_vld_ff, out_vld_in;
   adts_pkg::rsp_payload_type out_ff, out_in;

   // state as seen by this byte (restart clears first)
   logic [2:0]       ph_e;
   logic [3:0]       tidx_e;
   logic [LeftW-1:0] left_e;
   logic [LenW-1:0]  pos_e;
   logic [LenW-1:0]  len_e;
   logic [3:0]       rate_e;
   logic             err_e;

   logic [7:0]       b;
   logic [1:0]       kind;
   logic             last;
   logic             do_frame;
   logic [LenW-1:0]  fpos;
   logic [LenW-1:0]  flen;
   logic [3:0]       frate;
   logic             fbad;
   logic [3:0]       idx;
   logic [LeftW-1:0] left_sh;

   assign adv        = stage.vld && (!out_vld_ff || out_ready);
   assign b          = stage.data.byte_value;
   assign out_vld_in = adv || (out_vld_ff && !out_ready);

   always_comb begin
      if (stage.data.restart) begin
         ph_e   = PH_START;
         tidx_e = '0;
         left_e = '0;
         pos_e  = '0;
         len_e  = '0;
         rate_e = '0;
         err_e  = 1'b0;
      end else begin
         ph_e   = phase_ff;
         tidx_e = tidx_ff;
         left_e = left_ff;
         pos_e  = pos_ff;
         len_e  = len_ff;
         rate_e = rate_ff;
         err_e  = err_ff;
      end
   end

   // frame header decode at position fpos
   always_comb begin
      flen  = len_e;
      frate = rate_e;
      fbad  = 1'b0;
      unique case (fpos)
         13'd0: begin
            flen  = '0;
            frate = '0;
            fbad  = (b != 8'hFF);
         end
         13'd1: fbad = ((b & 8'hF6) != 8'hF0);
         13'd2: frate = b[5:2];
         13'd3: flen = {b[1:0], 11'd0};
         13'd4: flen = len_e | {2'd0, b, 3'd0};
         13'd5: begin
            flen = len_e | {10'd0, b[7:5]};
            fbad = (flen < 13'd7);
         end
         default: ;
      endcase
   end

   always_comb begin
      phase_in = ph_e;
      tidx_in  = tidx_e;
      left_in  = left_e;
      pos_in   = pos_e;
      len_in   = len_e;
      rate_in  = rate_e;
      err_in   = err_e;
      kind     = adts_pkg::KIND_REJECT;
      last     = 1'b0;
      do_frame = 1'b0;
      fpos     = pos_e;
      idx      = (tidx_e > 4'd9) ? 4'd9 : tidx_e;
      left_sh  = {left_e[LeftW-8:0], b[6:0]};

      unique case (ph_e)
         PH_START: begin
            if (b == 8'h49) begin
               phase_in = PH_TAG_HEAD;
               tidx_in  = 4'd1;
               left_in  = '0;
               kind     = adts_pkg::KIND_TAG;
            end else begin
               do_frame = 1'b1;
            end
         end
         PH_TAG_HEAD: begin
            if ((idx == 4'd1 && b != 8'h44) || (idx == 4'd2 && b != 8'h33)) begin
               err_in   = 1'b1;
               phase_in = PH_ERROR;
            end else begin
               kind = adts_pkg::KIND_TAG;
               if (idx >= 4'd6) begin
                  left_in = left_sh;
               end
               if (idx == 4'd9) begin
                  tidx_in  = '0;
                  phase_in = (left_in != '0) ? PH_TAG_BODY : PH_FRAME;
                  pos_in   = '0;
               end else begin
                  tidx_in = idx + 4'd1;
               end
            end
         end
         PH_TAG_BODY: begin
            if (left_e == '0) begin
               fpos     = '0;
               do_frame = 1'b1;
            end else begin
               kind    = adts_pkg::KIND_TAG;
               left_in = left_e - {{(LeftW-1){1'b0}}, 1'b1};
               if (left_e == {{(LeftW-1){1'b0}}, 1'b1}) begin
                  phase_in = PH_FRAME;
                  pos_in   = '0;
               end
            end
         end
         PH_FRAME: do_frame = 1'b1;
         default: begin
            err_in   = 1'b1;
            phase_in = PH_ERROR;
         end
      endcase

      if (do_frame) begin
         phase_in = PH_FRAME;
         len_in   = flen;
         rate_in  = frate;
         pos_in   = fpos;
         if (fbad) begin
            err_in   = 1'b1;
            phase_in = PH_ERROR;
         end else begin
            kind = (fpos < 13'd7) ? adts_pkg::KIND_HEADER : adts_pkg::KIND_PAYLOAD;
            if (fpos >= 13'd5 && ({1'b0, fpos} + 14'd1) >= {1'b0, flen}) begin
               last   = 1'b1;
               pos_in = '0;
            end else begin
               pos_in = fpos + 13'd1;
            end
         end
      end
   end

   always_comb begin
      out_in.out_byte     = b;
      out_in.byte_kind    = kind;
      out_in.frame_last   = last;
      out_in.frame_length = len_in;
      out_in.rate_index   = rate_in;
      out_in.sample_rate  = adts_pkg::rate_hz(rate_in);
      out_in.sync_error   = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         tidx_ff    <= '0;
         left_ff    <= '0;
         pos_ff     <= '0;
         len_ff     <= '0;
         rate_ff    <= '0;
         err_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (adv) begin
            phase_ff <= phase_in;
            tidx_ff  <= tidx_in;
            left_ff  <= left_in;
            pos_ff   <= pos_in;
            len_ff   <= len_in;
            rate_ff  <= rate_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;

   // once in error every byte is rejected and never closes a frame
   `ADTS_ASSERT_SAME(a_err_reject, clock, reset, out_vld_ff && out_ff.sync_error,
                     out_ff.byte_kind == adts_pkg::KIND_REJECT && !out_ff.frame_last)
   // error only clears on a restart byte
   `ADTS_ASSERT_NEXT(a_err_sticky, clock, reset, err_ff && !(adv && stage.data.restart), err_ff)
   // tag bytes never end a frame
   `ADTS_ASSERT_SAME(a_tag_no_last, clock, reset,
                     out_vld_ff && out_ff.byte_kind == adts_pkg::KIND_TAG, !out_ff.frame_last)
   // a stalled result holds
   `ADTS_ASSERT_NEXT(a_hold, clock, reset, out_vld_ff && !out_ready, out_vld_ff && $stable(out_ff))

endmodule

// ===== rtl/adts_stream_deframer.sv =====
// ---------------------------------------------------------------------------
// ADTS stream deframer
// Skips a leading ID3 tag, walks ADTS frames and labels every byte.
// ---------------------------------------------------------------------------
//  channel    dir  payload
//  req_chan   in   byte_value, restart
//  rsp_chan   out  out_byte, byte_kind, frame_last, frame_length,
//                  rate_index, sample_rate, sync_error
//
//  One byte per cycle sustained while rsp_chan is ready; a req byte passes
//  the input register, then the result register, before rsp valid rises.
//  All tag and frame counters update in a single pass per byte.
//  Synchronous active-high reset clears control state and parse state.
//  A stalled rsp holds its result; the input register still takes one byte.
// ---------------------------------------------------------------------------
module adts_stream_deframer (
   input logic       clock,
   input logic       reset,
   adts_req_if.sink   req_chan,
   adts_rsp_if.source rsp_chan
);

   adts_pkg::stage_type stage;
   logic                adv;

   adts_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_data  (req_chan.data),
      .adv      (adv),
      .stage    (stage)
   );

   adts_parser u_parse (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .adv       (adv),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.data)
   );

endmodule
